### src/azsc_pkg.sv
// Package for the auto-zero settle checker: sizes, codes and the
// request/response structs shared by the sequencer and the window unit.
// No dependencies.
package azsc_pkg;

    // Ring depth; the mean is a shift, so this stays a power of two.
    localparam int NUM_SAMPLES = 8;
    localparam int SMP_W       = 16;
    localparam int IDX_W       = $clog2(NUM_SAMPLES);
    localparam int CNT_W       = $clog2(NUM_SAMPLES + 1);
    localparam int SUM_W       = SMP_W + IDX_W;

    localparam int IC_W  = 10;
    localparam int EC_W  = 12;
    localparam int VAR_W = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 24;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SAMP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VARIANCE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_ZERO = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ZERO = 3'd5;

    // operations
    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // phases
    localparam logic [1:0] PH_IDLE       = 2'd0;
    localparam logic [1:0] PH_SETTLE_ON  = 2'd1;
    localparam logic [1:0] PH_SAMPLING   = 2'd2;
    localparam logic [1:0] PH_SETTLE_OFF = 2'd3;

    // status
    localparam logic [1:0] ST_UNDECIDED = 2'd0;
    localparam logic [1:0] ST_PASS      = 2'd1;
    localparam logic [1:0] ST_FAIL      = 2'd2;

    typedef struct packed {
        logic                    wr_en;
        logic [IDX_W-1:0]        wr_addr;
        logic signed [SMP_W-1:0] wr_data;
        logic                    start;
    } t_win_req;

    typedef struct packed {
        logic                    done;
        logic                    settled;
        logic signed [SMP_W-1:0] mean;
    } t_win_rsp;

endpackage

### src/azsc_window.sv
// Sample ring memory and window sweep: min, max and sum over the ring.
// Depends on azsc_pkg.
module azsc_window
    import azsc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_win_req           i_req,
    input  logic [VAR_W-1:0]   i_variance,
    output t_win_rsp           o_rsp
);

    logic signed [SMP_W-1:0] r_mem [NUM_SAMPLES];
    logic signed [SMP_W-1:0] r_rd_data;
    logic [IDX_W-1:0]        r_rd_addr;
    logic                    r_issue;
    logic                    r_rd_vld;
    logic                    r_rd_last;
    logic                    r_first;
    logic                    r_fin;
    logic signed [SMP_W-1:0] r_min;
    logic signed [SMP_W-1:0] r_max;
    logic signed [SUM_W-1:0] r_sum;

    logic signed [SMP_W:0]   range_s;
    logic signed [SUM_W-1:0] sum_adj;
    logic signed [SUM_W-1:0] mean_full;

    // Memory: one write port, one registered read port. The write lands on
    // the start edge and reads begin in the cycle after, so no forwarding needed.
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (r_issue) begin
            r_rd_data <= r_mem[r_rd_addr];
        end
        r_rd_last <= (r_rd_addr == IDX_W'(NUM_SAMPLES - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue   <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_fin     <= 1'b0;
            r_first   <= 1'b0;
            r_rd_addr <= '0;
        end else begin
            r_rd_vld <= r_issue;
            r_fin    <= r_rd_vld && r_rd_last;
            if (i_req.start) begin
                r_issue   <= 1'b1;
                r_rd_addr <= '0;
                r_first   <= 1'b1;
            end else if (r_issue) begin
                r_rd_addr <= r_rd_addr + 1'b1;
                if (r_rd_addr == IDX_W'(NUM_SAMPLES - 1)) begin
                    r_issue <= 1'b0;
                end
            end
            if (r_rd_vld) begin
                r_first <= 1'b0;
            end
        end
    end

    // accumulators
    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            if (r_first) begin
                r_min <= r_rd_data;
                r_max <= r_rd_data;
                r_sum <= SUM_W'(r_rd_data);
            end else begin
                if (r_rd_data < r_min) r_min <= r_rd_data;
                if (r_rd_data > r_max) r_max <= r_rd_data;
                r_sum <= r_sum + SUM_W'(r_rd_data);
            end
        end
    end

    // all pairs within variance <=> max - min below variance
    assign range_s   = {r_max[SMP_W-1], r_max} - {r_min[SMP_W-1], r_min};
    // truncate toward zero: bias negative sums before the shift
    assign sum_adj   = r_sum + (r_sum[SUM_W-1] ? SUM_W'(NUM_SAMPLES - 1) : SUM_W'(0));
    assign mean_full = sum_adj >>> IDX_W;

    assign o_rsp.done    = r_fin;
    assign o_rsp.settled = $unsigned(range_s) < {1'b0, i_variance};
    assign o_rsp.mean    = mean_full[SMP_W-1:0];

endmodule

### src/sensor_auto_zero_settle_check_top.sv
// Auto-zero settle checker, top level: config registers, phase sequencer,
// output register. Depends on azsc_pkg and azsc_window.
//
//  channel   | direction | payload
//  ----------+-----------+--------------------------------------------------
//  s_axis    | in        | tuser: operation; tdata: pressure_sample
//  m_axis    | out       | tdata: phase, done_res, status, zero_value
//  cfg       | in        | i_cfg_index (register), i_cfg_data (value)
//
// A start or a tick without a full-ring check is accepted, then loads the
// output register. A sample that completes the ring runs a window sweep
// through the ring memory, one entry per cycle, before the output load.
// Reset clears the sequencer, counters and status; the ring is not cleared,
// since a start empties it logically and entries are written before read.
// Input is taken only while the sequencer is idle; a result waiting on
// m_axis does not block the next input, only the next result load.
module sensor_auto_zero_settle_check_top
    import azsc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // config write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [15:0] pressure_sample
    input  logic                  s_axis_tuser,   // [0] operation
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata    // [1:0] phase, [2] done_res,
                                                  // [4:3] status, [20:5] zero_value
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_EMIT  = 2'd2;

    localparam logic [IC_W-1:0] IC_MAX = '1;
    localparam logic [EC_W-1:0] EC_MAX = '1;

    // config registers
    logic [IC_W-1:0]         r_settle;
    logic [IC_W-1:0]         r_interval;
    logic [EC_W-1:0]         r_max_samp;
    logic [VAR_W-1:0]        r_variance;
    logic signed [SMP_W-1:0] r_min_zero;
    logic signed [SMP_W-1:0] r_max_zero;

    // sequencer state
    logic [1:0]              r_state, n_state;
    logic [1:0]              r_phase, n_phase;
    logic [IC_W-1:0]         r_ic, n_ic;
    logic [EC_W-1:0]         r_ec, n_ec;
    logic [CNT_W-1:0]        r_sc, n_sc;
    logic [IDX_W-1:0]        r_wi, n_wi;
    logic [1:0]              r_status, n_status;
    logic signed [SMP_W-1:0] r_zero, n_zero;
    logic                    r_done, n_done;

    logic                    r_m_valid;
    logic [OUT_DATA_W-1:0]   r_m_data;

    logic                    s_xfer;
    logic                    out_load;
    logic [IC_W-1:0]         ic_inc;
    logic [EC_W-1:0]         ec_inc;
    logic [CNT_W-1:0]        sc_take;
    t_win_req                win_req;
    t_win_rsp                win_rsp;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign s_xfer        = s_axis_tvalid && s_axis_tready;
    assign out_load      = (r_state == S_EMIT) && (!r_m_valid || m_axis_tready);

    assign ic_inc  = (r_ic == IC_MAX) ? r_ic : r_ic + 1'b1;
    assign ec_inc  = (r_ec == EC_MAX) ? r_ec : r_ec + 1'b1;
    assign sc_take = (r_sc < CNT_W'(NUM_SAMPLES)) ? r_sc + 1'b1 : r_sc;

    // config writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle   <= IC_W'(50);
            r_interval <= IC_W'(20);
            r_max_samp <= EC_W'(100);
            r_variance <= VAR_W'(16);
            r_min_zero <= -SMP_W'(1000);
            r_max_zero <= SMP_W'(1000);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_SETTLE:   r_settle   <= i_cfg_data[IC_W-1:0];
                REG_INTERVAL: r_interval <= i_cfg_data[IC_W-1:0];
                REG_MAX_SAMP: r_max_samp <= i_cfg_data[EC_W-1:0];
                REG_VARIANCE: r_variance <= i_cfg_data[VAR_W-1:0];
                REG_MIN_ZERO: r_min_zero <= i_cfg_data[SMP_W-1:0];
                REG_MAX_ZERO: r_max_zero <= i_cfg_data[SMP_W-1:0];
                default: ;
            endcase
        end
    end

    // next-state logic
    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_ic     = r_ic;
        n_ec     = r_ec;
        n_sc     = r_sc;
        n_wi     = r_wi;
        n_status = r_status;
        n_zero   = r_zero;
        n_done   = r_done;
        win_req  = '0;
        unique case (r_state)
            S_IDLE: begin
                if (s_xfer) begin
                    n_done  = 1'b0;
                    n_state = S_EMIT;
                    if (s_axis_tuser == OP_START) begin
                        n_phase  = PH_SETTLE_ON;
                        n_ic     = '0;
                        n_ec     = '0;
                        n_sc     = '0;
                        n_wi     = '0;
                        n_status = ST_UNDECIDED;
                    end else begin
                        unique case (r_phase)
                            PH_SETTLE_ON: begin
                                n_ic = ic_inc;
                                if (ic_inc >= r_settle) begin
                                    n_phase = PH_SAMPLING;
                                    n_sc    = '0;
                                    n_ic    = '0;
                                end
                            end
                            PH_SAMPLING: begin
                                if (r_sc != '0) n_ec = ec_inc;
                                n_ic = ic_inc;
                                if (ic_inc >= r_interval) begin
                                    n_ic            = '0;
                                    // elapsed time counts from the first sample
                                    if (r_sc == '0) n_ec = '0;
                                    n_sc            = sc_take;
                                    n_wi            = (r_wi == IDX_W'(NUM_SAMPLES - 1))
                                                      ? '0 : r_wi + 1'b1;
                                    win_req.wr_en   = 1'b1;
                                    win_req.wr_addr = r_wi;
                                    win_req.wr_data = s_axis_tdata[SMP_W-1:0];
                                    if (sc_take == CNT_W'(NUM_SAMPLES)) begin
                                        win_req.start = 1'b1;
                                        n_state       = S_CHECK;
                                    end
                                end
                            end
                            PH_SETTLE_OFF: begin
                                n_ic = ic_inc;
                                if (ic_inc >= r_settle) begin
                                    n_phase = PH_IDLE;
                                    n_ic    = '0;
                                    n_done  = 1'b1;
                                end
                            end
                            PH_IDLE: ;
                            default: ;
                        endcase
                    end
                end
            end
            S_CHECK: begin
                if (win_rsp.done) begin
                    n_state = S_EMIT;
                    if (win_rsp.settled) begin
                        n_zero   = win_rsp.mean;
                        n_status = (win_rsp.mean > r_min_zero && win_rsp.mean < r_max_zero)
                                   ? ST_PASS : ST_FAIL;
                        n_phase  = PH_SETTLE_OFF;
                        n_ic     = '0;
                    end else if (r_ec > r_max_samp) begin
                        n_status = ST_FAIL;
                        n_phase  = PH_SETTLE_OFF;
                        n_ic     = '0;
                    end
                end
            end
            S_EMIT: begin
                if (out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= PH_IDLE;
            r_ic     <= '0;
            r_ec     <= '0;
            r_sc     <= '0;
            r_wi     <= '0;
            r_status <= ST_UNDECIDED;
            r_zero   <= '0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_ic     <= n_ic;
            r_ec     <= n_ec;
            r_sc     <= n_sc;
            r_wi     <= n_wi;
            r_status <= n_status;
            r_zero   <= n_zero;
            r_done   <= n_done;
        end
    end

    // output register: parts the result side from the input side
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_data <= {3'b000, r_zero, r_status, r_done, r_phase};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    azsc_window u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (win_req),
        .i_variance (r_variance),
        .o_rsp      (win_rsp)
    );

endmodule

### src/azsc_checker.sv
// Port-level checks for the auto-zero settle checker, bound to the top.
// Depends on azsc_pkg and sensor_auto_zero_settle_check_top.
module azsc_checker
    import azsc_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // no result straight out of reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // one item at a time: no input taken the cycle after a transfer
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while previous item in flight");

    // completion only reported with the phase back at idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[1:0] == PH_IDLE)
        else $error("done flagged outside idle phase");

    // status code never out of range
    a_status_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[4:3] != 2'b11)
        else $error("bad status code");

endmodule

bind sensor_auto_zero_settle_check_top azsc_checker u_azsc_checker (.*);
